### hdl/bmm_pkg.sv
// Shared constants, codes and controller command type for the boot memory map collector.
package bmm_pkg;

	localparam int USABLE_DEPTH   = 32;
	localparam int RESERVED_DEPTH = 8;

	localparam int ADDR_W = 64;
	localparam int TYPE_W = 32;
	localparam int OP_W   = 2;
	localparam int RES_W  = 2;
	localparam int IDX_W  = 5;

	localparam int UCNT_W = $clog2(USABLE_DEPTH + 1);
	localparam int RCNT_W = $clog2(RESERVED_DEPTH + 1);
	localparam int UAW    = (USABLE_DEPTH > 1) ? $clog2(USABLE_DEPTH) : 1;
	localparam int RAW    = (RESERVED_DEPTH > 1) ? $clog2(RESERVED_DEPTH) : 1;

	localparam int PAGE_SHIFT = 12;
	localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
	localparam logic [OP_W-1:0] OP_DESC     = 2'd1;
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd2;
	localparam logic [OP_W-1:0] OP_READ     = 2'd3;

	localparam logic [RES_W-1:0] RES_NONE     = 2'd0;
	localparam logic [RES_W-1:0] RES_APPENDED = 2'd1;
	localparam logic [RES_W-1:0] RES_MERGED   = 2'd2;
	localparam logic [RES_W-1:0] RES_DROPPED  = 2'd3;

	localparam logic [TYPE_W-1:0] MT_LOADER_CODE   = 32'd1;
	localparam logic [TYPE_W-1:0] MT_LOADER_DATA   = 32'd2;
	localparam logic [TYPE_W-1:0] MT_BOOT_CODE     = 32'd3;
	localparam logic [TYPE_W-1:0] MT_BOOT_DATA     = 32'd4;
	localparam logic [TYPE_W-1:0] MT_RUNTIME_CODE  = 32'd5;
	localparam logic [TYPE_W-1:0] MT_RUNTIME_DATA  = 32'd6;
	localparam logic [TYPE_W-1:0] MT_CONVENTIONAL  = 32'd7;

	typedef struct packed {
		logic load;
		logic clear;
		logic rd;
		logic take;
		logic calc_end;
		logic round;
		logic apply;
		logic net;
		logic acc;
	} cmd_t;

endpackage

### hdl/boot_memory_map_collector_top.sv
// Top level of the boot memory map collector: sequencer plus datapath.
//
// One transaction is taken when start is high and busy is low; its result is shown for
// exactly one cycle with done high and cannot be held off, so capture it on that cycle.
// Done rises after a clear is accepted, after the registered table RAM read for a table
// read, and for a descriptor or reserved region after the sequencer has stepped through
// the end-address add, page rounding, table update, page-difference subtract and the
// available-page accumulate, one state each. A new transaction may be accepted in the
// cycle that done is high. Tables are tracked by fill count, so no clearing pass follows
// reset or a clear.
module boot_memory_map_collector_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	output logic                        done,
	input  logic [bmm_pkg::OP_W-1:0]    operation,
	input  logic [bmm_pkg::TYPE_W-1:0]  mem_type,
	input  logic [bmm_pkg::ADDR_W-1:0]  region_start,
	input  logic [bmm_pkg::ADDR_W-1:0]  region_amount,
	input  logic                        round_to_page,
	input  logic                        table_select,
	input  logic [bmm_pkg::IDX_W-1:0]   entry_index,
	output logic [bmm_pkg::RES_W-1:0]   range_result,
	output logic [bmm_pkg::UCNT_W-1:0]  usable_count,
	output logic [bmm_pkg::RCNT_W-1:0]  reserved_count,
	output logic [bmm_pkg::ADDR_W-1:0]  conv_total,
	output logic [bmm_pkg::ADDR_W-1:0]  ldr_total,
	output logic [bmm_pkg::ADDR_W-1:0]  bsvc_total,
	output logic [bmm_pkg::ADDR_W-1:0]  rtsvc_total,
	output logic [bmm_pkg::ADDR_W-1:0]  avail_total,
	output logic [bmm_pkg::ADDR_W-1:0]  entry_start,
	output logic [bmm_pkg::ADDR_W-1:0]  entry_end
);
	import bmm_pkg::*;

	cmd_t cmd;

	bmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	bmm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.operation      (operation),
		.mem_type       (mem_type),
		.region_start   (region_start),
		.region_amount  (region_amount),
		.round_to_page  (round_to_page),
		.table_select   (table_select),
		.entry_index    (entry_index),
		.range_result   (range_result),
		.usable_count   (usable_count),
		.reserved_count (reserved_count),
		.conv_total     (conv_total),
		.ldr_total      (ldr_total),
		.bsvc_total     (bsvc_total),
		.rtsvc_total    (rtsvc_total),
		.avail_total    (avail_total),
		.entry_start    (entry_start),
		.entry_end      (entry_end)
	);

endmodule

### hdl/bmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/bmm_ctrl.sv
// Sequencer for the boot memory map collector: steps each transaction through the datapath.
module bmm_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [bmm_pkg::OP_W-1:0] operation,
	output logic                     busy,
	output logic                     done,
	output bmm_pkg::cmd_t            cmd
);
	import bmm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_RD,
		S_RDATA,
		S_END,
		S_ROUND,
		S_CHECK,
		S_NET,
		S_ACC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (operation)
							OP_CLEAR: state_q <= S_CLR;
							OP_READ:  state_q <= S_RD;
							default:  state_q <= S_END;
						endcase
					end
				end
				S_CLR: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_RD:    state_q <= S_RDATA;
				S_RDATA: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_END:   state_q <= S_ROUND;
				S_ROUND: state_q <= S_CHECK;
				S_CHECK: state_q <= S_NET;
				S_NET:   state_q <= S_ACC;
				S_ACC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = start && (state_q == S_IDLE);
		cmd.clear    = (state_q == S_CLR);
		cmd.rd       = (state_q == S_RD);
		cmd.take     = (state_q == S_RDATA);
		cmd.calc_end = (state_q == S_END);
		cmd.round    = (state_q == S_ROUND);
		cmd.apply    = (state_q == S_CHECK);
		cmd.net      = (state_q == S_NET);
		cmd.acc      = (state_q == S_ACC);
	end

`ifndef SYNTH
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");
`endif

endmodule

### hdl/bmm_datapath.sv
// Datapath of the boot memory map collector: range tables, page totals and result registers.
module bmm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bmm_pkg::cmd_t               cmd,
	input  logic [bmm_pkg::OP_W-1:0]    operation,
	input  logic [bmm_pkg::TYPE_W-1:0]  mem_type,
	input  logic [bmm_pkg::ADDR_W-1:0]  region_start,
	input  logic [bmm_pkg::ADDR_W-1:0]  region_amount,
	input  logic                        round_to_page,
	input  logic                        table_select,
	input  logic [bmm_pkg::IDX_W-1:0]   entry_index,
	output logic [bmm_pkg::RES_W-1:0]   range_result,
	output logic [bmm_pkg::UCNT_W-1:0]  usable_count,
	output logic [bmm_pkg::RCNT_W-1:0]  reserved_count,
	output logic [bmm_pkg::ADDR_W-1:0]  conv_total,
	output logic [bmm_pkg::ADDR_W-1:0]  ldr_total,
	output logic [bmm_pkg::ADDR_W-1:0]  bsvc_total,
	output logic [bmm_pkg::ADDR_W-1:0]  rtsvc_total,
	output logic [bmm_pkg::ADDR_W-1:0]  avail_total,
	output logic [bmm_pkg::ADDR_W-1:0]  entry_start,
	output logic [bmm_pkg::ADDR_W-1:0]  entry_end
);
	import bmm_pkg::*;

	logic [OP_W-1:0]   op_q;
	logic [TYPE_W-1:0] type_q;
	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] amount_q;
	logic              round_q;
	logic              sel_q;
	logic [IDX_W-1:0]  idx_q;
	logic              hit_q;

	logic [ADDR_W-1:0] end_q;
	logic [ADDR_W-1:0] add_q;
	logic [ADDR_W-1:0] sub_q;
	logic [ADDR_W-1:0] net_q;

	logic [UCNT_W-1:0] ucnt_q;
	logic [RCNT_W-1:0] rcnt_q;
	logic [ADDR_W-1:0] conv_q;
	logic [ADDR_W-1:0] loader_q;
	logic [ADDR_W-1:0] boot_q;
	logic [ADDR_W-1:0] runtime_q;
	logic [ADDR_W-1:0] avail_q;
	logic [RES_W-1:0]  result_q;
	logic [ADDR_W-1:0] entry_start_q;
	logic [ADDR_W-1:0] entry_end_q;

	logic [ADDR_W-1:0] ulast_start_q;
	logic [ADDR_W-1:0] ulast_end_q;
	logic [ADDR_W-1:0] rlast_start_q;
	logic [ADDR_W-1:0] rlast_end_q;

	logic                  is_usable;
	logic                  is_conv;
	logic                  in_range;
	logic                  cnt_nonzero;
	logic                  is_full;
	logic [ADDR_W-1:0]     last_start;
	logic [ADDR_W-1:0]     last_end;
	logic                  do_merge;
	logic                  do_append;
	logic [RES_W-1:0]      apply_res;
	logic [UCNT_W-1:0]     ucnt_dec;
	logic [RCNT_W-1:0]     rcnt_dec;
	logic                  u_we;
	logic                  r_we;
	logic [UAW-1:0]        u_waddr;
	logic [RAW-1:0]        r_waddr;
	logic [2*ADDR_W-1:0]   wdata;
	logic [2*ADDR_W-1:0]   u_rdata;
	logic [2*ADDR_W-1:0]   r_rdata;
	logic [ADDR_W-1:0]     span;

	always_comb begin
		is_usable   = (op_q == OP_DESC);
		is_conv     = (type_q == MT_CONVENTIONAL);
		in_range    = (start_q != '0) && (end_q > start_q);
		cnt_nonzero = is_usable ? (ucnt_q != '0) : (rcnt_q != '0);
		is_full     = is_usable ? (ucnt_q == UCNT_W'(USABLE_DEPTH))
		                        : (rcnt_q == RCNT_W'(RESERVED_DEPTH));
		last_start  = is_usable ? ulast_start_q : rlast_start_q;
		last_end    = is_usable ? ulast_end_q : rlast_end_q;
		do_merge    = 1'b0;
		do_append   = 1'b0;
		apply_res   = RES_NONE;
		if ((!is_usable || is_conv) && in_range) begin
			if (cnt_nonzero && (last_end == start_q)) begin
				do_merge  = 1'b1;
				apply_res = RES_MERGED;
			end else if (is_full) begin
				apply_res = RES_DROPPED;
			end else begin
				do_append = 1'b1;
				apply_res = RES_APPENDED;
			end
		end
		ucnt_dec = ucnt_q - UCNT_W'(1);
		rcnt_dec = rcnt_q - RCNT_W'(1);
		u_waddr  = do_merge ? ucnt_dec[UAW-1:0] : ucnt_q[UAW-1:0];
		r_waddr  = do_merge ? rcnt_dec[RAW-1:0] : rcnt_q[RAW-1:0];
		wdata    = do_merge ? {last_start, end_q} : {start_q, end_q};
		u_we     = cmd.apply && is_usable && (do_merge || do_append);
		r_we     = cmd.apply && !is_usable && (do_merge || do_append);
		span     = do_merge ? (end_q - last_start) : (end_q - start_q);
	end

	bmm_ram #(
		.WIDTH (2 * ADDR_W),
		.DEPTH (USABLE_DEPTH)
	) u_usable_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (UAW'(idx_q)),
		.rdata (u_rdata)
	);

	bmm_ram #(
		.WIDTH (2 * ADDR_W),
		.DEPTH (RESERVED_DEPTH)
	) u_reserved_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (wdata),
		.re    (cmd.rd),
		.raddr (RAW'(idx_q)),
		.rdata (r_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= operation;
			type_q   <= mem_type;
			start_q  <= region_start;
			amount_q <= region_amount;
			round_q  <= round_to_page;
			sel_q    <= table_select;
			idx_q    <= entry_index;
		end
		if (cmd.rd) begin
			hit_q <= sel_q ? (32'(idx_q) < 32'(rcnt_q)) : (32'(idx_q) < 32'(ucnt_q));
		end
		if (cmd.calc_end) begin
			end_q <= start_q + (is_usable ? (amount_q << PAGE_SHIFT) : amount_q);
		end
		if (cmd.round && !is_usable && round_q) begin
			end_q <= (end_q + PAGE_MASK) & ~PAGE_MASK;
		end
		if (cmd.apply) begin
			add_q <= (is_usable && (do_merge || do_append)) ? span : '0;
			sub_q <= (is_usable && do_merge) ? (last_end - last_start) : '0;
			if (is_usable && do_merge) begin
				ulast_end_q <= end_q;
			end
			if (is_usable && do_append) begin
				ulast_start_q <= start_q;
				ulast_end_q   <= end_q;
			end
			if (!is_usable && do_merge) begin
				rlast_end_q <= end_q;
			end
			if (!is_usable && do_append) begin
				rlast_start_q <= start_q;
				rlast_end_q   <= end_q;
			end
		end
		if (cmd.net) begin
			net_q <= (add_q >> PAGE_SHIFT) - (sub_q >> PAGE_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ucnt_q        <= '0;
			rcnt_q        <= '0;
			conv_q        <= '0;
			loader_q      <= '0;
			boot_q        <= '0;
			runtime_q     <= '0;
			avail_q       <= '0;
			result_q      <= RES_NONE;
			entry_start_q <= '0;
			entry_end_q   <= '0;
		end else begin
			if (cmd.load) begin
				result_q      <= RES_NONE;
				entry_start_q <= '0;
				entry_end_q   <= '0;
			end
			if (cmd.clear) begin
				ucnt_q    <= '0;
				rcnt_q    <= '0;
				conv_q    <= '0;
				loader_q  <= '0;
				boot_q    <= '0;
				runtime_q <= '0;
				avail_q   <= '0;
			end
			if (cmd.take && hit_q) begin
				entry_start_q <= sel_q ? r_rdata[2*ADDR_W-1:ADDR_W] : u_rdata[2*ADDR_W-1:ADDR_W];
				entry_end_q   <= sel_q ? r_rdata[ADDR_W-1:0] : u_rdata[ADDR_W-1:0];
			end
			if (cmd.calc_end && is_usable) begin
				case (type_q)
					MT_CONVENTIONAL:                 conv_q    <= conv_q + amount_q;
					MT_LOADER_CODE, MT_LOADER_DATA:  loader_q  <= loader_q + amount_q;
					MT_BOOT_CODE, MT_BOOT_DATA:      boot_q    <= boot_q + amount_q;
					MT_RUNTIME_CODE, MT_RUNTIME_DATA: runtime_q <= runtime_q + amount_q;
					default: ;
				endcase
			end
			if (cmd.apply) begin
				result_q <= apply_res;
				if (do_append && is_usable) begin
					ucnt_q <= ucnt_q + UCNT_W'(1);
				end
				if (do_append && !is_usable) begin
					rcnt_q <= rcnt_q + RCNT_W'(1);
				end
			end
			if (cmd.acc) begin
				avail_q <= avail_q + net_q;
			end
		end
	end

	assign range_result   = result_q;
	assign usable_count   = ucnt_q;
	assign reserved_count = rcnt_q;
	assign conv_total     = conv_q;
	assign ldr_total      = loader_q;
	assign bsvc_total     = boot_q;
	assign rtsvc_total    = runtime_q;
	assign avail_total    = avail_q;
	assign entry_start    = entry_start_q;
	assign entry_end      = entry_end_q;

`ifndef SYNTH
	a_ucnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ucnt_q != $past(ucnt_q)) |-> (ucnt_q == $past(ucnt_q) + UCNT_W'(1)) || (ucnt_q == '0))
		else $error("usable count moved by other than one append or a clear");

	a_rcnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rcnt_q != $past(rcnt_q)) |-> (rcnt_q == $past(rcnt_q) + RCNT_W'(1)) || (rcnt_q == '0))
		else $error("reserved count moved by other than one append or a clear");
`endif

endmodule
